// ===== design/lsp_pkg.sv =====
// Shared types and constants for the LIFO stack with peek.
// Used by the controller, the datapath and the top level; depends on nothing.
package lsp_pkg;

  // Default number of storage words in the stack.
  localparam int unsigned DEFAULT_DEPTH = 16;

  // Width of the count, capacity and position fields.
  localparam int unsigned CNT_W = 5;

  // Width of one stored word.
  localparam int unsigned WORD_W = 32;

  // Capacity register value after reset.
  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_TOP    = 3'd3,
    CMD_BOTTOM = 3'd4
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADPOS    = 2'd3
  } status_e_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;  // Capture the incoming command beat.
    logic exec;  // Execute the captured command against the stack.
  } dp_cmd_t;

endpackage

// ===== design/lsp_ctrl.sv =====
// Sequencing state machine for the LIFO stack with peek.
// Depends on lsp_pkg for the state type and the datapath command struct.
module lsp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output logic             done,
  output lsp_pkg::dp_cmd_t dp_cmd
);
  import lsp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    busy        = 1'b1;
    done        = 1'b0;
    dp_cmd.load = 1'b0;
    dp_cmd.exec = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          dp_cmd.load = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        dp_cmd.exec = 1'b1;
        state_next  = S_RESP;
      end
      S_RESP: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/lsp_datapath.sv =====
// Stack storage, count and capacity registers, and result formation.
// Depends on lsp_pkg for command and status codes and the command struct.
module lsp_datapath #(
  parameter int unsigned DEPTH = lsp_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lsp_pkg::dp_cmd_t                  dp_cmd,
  input  logic [2:0]                        command,
  input  logic signed [lsp_pkg::WORD_W-1:0] push_value,
  input  logic [lsp_pkg::CNT_W-1:0]         position,
  input  logic                              cfg_wr,
  input  logic [lsp_pkg::CNT_W-1:0]         cfg_data,
  output logic signed [lsp_pkg::WORD_W-1:0] read_data,
  output logic [1:0]                        status,
  output logic [lsp_pkg::CNT_W-1:0]         entry_count,
  output logic                              is_empty,
  output logic                              is_full
);
  import lsp_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned MaxCount = (1 << CNT_W) - 1;
  localparam int unsigned CapLimitInt = (DEPTH < MaxCount) ? DEPTH : MaxCount;
  localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(CapLimitInt);

  logic [WORD_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0]  capacity;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [2:0]        held_cmd;
  logic [WORD_W-1:0] held_value;
  logic [CNT_W-1:0]  held_pos;
  status_e_t         result_status;
  status_e_t         result_status_next;
  logic              data_sel;
  logic              data_sel_next;
  logic [WORD_W-1:0] read_word;
  logic [CNT_W-1:0]  raddr;
  logic              we;
  logic [CNT_W-1:0]  cap_eff;

  // A capacity above the storage depth acts as the depth.
  assign cap_eff = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;

  always_comb begin
    result_status_next = ST_OK;
    count_next         = count;
    we                 = 1'b0;
    raddr              = '0;
    data_sel_next      = 1'b0;
    case (held_cmd)
      CMD_PUSH: begin
        if (count >= cap_eff) begin
          result_status_next = ST_OVERFLOW;
        end else begin
          we         = 1'b1;
          count_next = count + 1'b1;
        end
      end
      CMD_POP: begin
        if (count == '0) begin
          result_status_next = ST_UNDERFLOW;
        end else begin
          count_next    = count - 1'b1;
          raddr         = count - 1'b1;
          data_sel_next = 1'b1;
        end
      end
      CMD_PEEK: begin
        if (held_pos == '0 || held_pos > count) begin
          result_status_next = ST_BADPOS;
        end else begin
          raddr         = count - held_pos;
          data_sel_next = 1'b1;
        end
      end
      CMD_TOP: begin
        if (count == '0) begin
          result_status_next = ST_UNDERFLOW;
        end else begin
          raddr         = count - 1'b1;
          data_sel_next = 1'b1;
        end
      end
      CMD_BOTTOM: begin
        if (count == '0) begin
          result_status_next = ST_UNDERFLOW;
        end else begin
          data_sel_next = 1'b1;
        end
      end
      default: begin
        result_status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      count    <= '0;
    end else begin
      if (cfg_wr) begin
        capacity <= cfg_data;
      end
      if (dp_cmd.exec) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      held_cmd   <= command;
      held_value <= push_value;
      held_pos   <= position;
    end
    if (dp_cmd.exec) begin
      result_status <= result_status_next;
      data_sel      <= data_sel_next;
    end
  end

  // Pushes only succeed while count is below the depth, so the write address fits.
  always_ff @(posedge clk) begin
    if (dp_cmd.exec && we) begin
      mem[AW'(count)] <= held_value;
    end
    if (dp_cmd.exec) begin
      read_word <= mem[AW'(raddr)];
    end
  end

  assign read_data   = data_sel ? read_word : '0;
  assign status      = result_status;
  assign entry_count = count;
  assign is_empty    = (count == '0);
  assign is_full     = (count >= cap_eff);

endmodule

// ===== design/lifo_stack_with_peek_core.sv =====
// LIFO stack with peek: top level joining the controller and the datapath.
// A command beat is captured, executed against the stack with a registered storage read,
// and answered with its result strobe in the respond step; a new beat is taken only
// once the previous command has been answered and the controller is back in idle.
// Reset: synchronous, active high; clears the count, sets capacity to 16, and leaves
// the stored words undefined. The receiver cannot stall, so each result lasts one cycle.
module lifo_stack_with_peek_core #(
  parameter int unsigned DEPTH = lsp_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // Command channel: a beat is taken when start is high and busy is low.
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        command,
  input  logic signed [lsp_pkg::WORD_W-1:0] push_value,
  input  logic [lsp_pkg::CNT_W-1:0]         position,
  // Capacity register write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lsp_pkg::CNT_W-1:0]         cfg_data,
  // Result channel: valid for the single cycle in which done is high.
  output logic                              done,
  output logic signed [lsp_pkg::WORD_W-1:0] read_data,
  output logic [1:0]                        status,
  output logic [lsp_pkg::CNT_W-1:0]         entry_count,
  output logic                              is_empty,
  output logic                              is_full
);
  import lsp_pkg::*;

  dp_cmd_t dp_cmd;
  logic    cfg_wr;

  // The capacity register is written only between commands, so the
  // configuration channel is open exactly when the command channel is.
  assign cfg_ready = ~busy;
  assign cfg_wr    = cfg_valid & cfg_ready;

  // The controller steps each command through capture, execute and respond.
  lsp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .dp_cmd (dp_cmd)
  );

  // The datapath holds the words, the count and the capacity, and forms
  // the result fields that are presented while done is high.
  lsp_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .dp_cmd      (dp_cmd),
    .command     (command),
    .push_value  (push_value),
    .position    (position),
    .cfg_wr      (cfg_wr),
    .cfg_data    (cfg_data),
    .read_data   (read_data),
    .status      (status),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .is_full     (is_full)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lifo_stack_with_peek_core: random and directed stack commands,
// capacity rewrites between phases, and results checked against an in-bench stack predictor.
// Depends on lsp_pkg and the core RTL only.
module testbench;
  import lsp_pkg::*;

  localparam int unsigned STACK_DEPTH = DEFAULT_DEPTH;
  // Cycles to let pass once all results are in, before a capacity write and at the end.
  localparam int unsigned SETTLE_CYCLES = 6;
  // Hard stop.
  localparam int unsigned CYCLE_LIMIT = 200000;

  // What one entry of the stimulus queue asks the driver to do.
  typedef enum logic [1:0] {
    BEAT_CMD,
    BEAT_CFG,
    BEAT_DRAIN
  } beat_kind_t;

  typedef struct packed {
    beat_kind_t              kind;
    logic [2:0]              op;
    logic signed [WORD_W-1:0] value;
    logic [CNT_W-1:0]        pos;
    logic [CNT_W-1:0]        cap;
  } stack_beat_t;

  // One predicted result, field for field with the result ports.
  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    status_e_t               code;
    logic [CNT_W-1:0]        count;
    logic                    empty;
    logic                    full;
  } stack_reply_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [2:0]               command = '0;
  logic signed [WORD_W-1:0] push_value = '0;
  logic [CNT_W-1:0]         position = '0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CNT_W-1:0]         cfg_data = '0;
  logic                     done;
  logic signed [WORD_W-1:0] read_data;
  logic [1:0]               status;
  logic [CNT_W-1:0]         entry_count;
  logic                     is_empty;
  logic                     is_full;

  // Stimulus waiting to be driven, and results the stack still owes us.
  stack_beat_t  pending_beats[$];
  stack_reply_t owed_replies[$];

  // Predictor state: a private copy of the stack and its capacity register.
  logic signed [WORD_W-1:0] model_words [STACK_DEPTH];
  int unsigned              model_count = 0;
  logic [CNT_W-1:0]         model_cap = CAP_RESET;

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Driver bookkeeping: idle cycles before the next command and the drain timer.
  int unsigned send_gap = 0;
  int unsigned settle = 0;
  bit          quiet_run = 1'b0;

  lifo_stack_with_peek_core dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .push_value  (push_value),
    .position    (position),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .done        (done),
    .read_data   (read_data),
    .status      (status),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .is_full     (is_full)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               owed_replies.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Applies one command to the private stack and returns the result it must produce.
  // The capacity acts as at most the storage depth; zero means every push overflows.
  // A lowered capacity keeps the words already stored, it only blocks further pushes.
  function automatic stack_reply_t apply_stack_cmd(input logic [2:0] op,
                                                   input logic signed [WORD_W-1:0] value,
                                                   input logic [CNT_W-1:0] pos);
    stack_reply_t r;
    int unsigned  lim;
    lim = (model_cap > STACK_DEPTH) ? STACK_DEPTH : model_cap;
    r.data = '0;
    r.code = ST_OK;
    case (op)
      CMD_PUSH: begin
        if (model_count >= lim) begin
          r.code = ST_OVERFLOW;
        end else begin
          model_words[model_count] = value;
          model_count++;
        end
      end
      CMD_POP: begin
        if (model_count == 0) begin
          r.code = ST_UNDERFLOW;
        end else begin
          model_count--;
          r.data = model_words[model_count];
        end
      end
      CMD_PEEK: begin
        // Position one is the top; zero or anything past the count is rejected.
        if (pos == 0 || pos > model_count) begin
          r.code = ST_BADPOS;
        end else begin
          r.data = model_words[model_count - pos];
        end
      end
      CMD_TOP: begin
        if (model_count == 0) begin
          r.code = ST_UNDERFLOW;
        end else begin
          r.data = model_words[model_count - 1];
        end
      end
      CMD_BOTTOM: begin
        if (model_count == 0) begin
          r.code = ST_UNDERFLOW;
        end else begin
          r.data = model_words[0];
        end
      end
      default: begin
        // The three unused codes leave the stack alone and report success.
      end
    endcase
    r.count = model_count[CNT_W-1:0];
    r.empty = (model_count == 0);
    r.full  = (model_count >= lim);
    return r;
  endfunction

  // Driver. Commands and capacity writes come off pending_beats in order. A command beat
  // is taken at an edge with start high and busy low; the prediction is made right there,
  // from the values that were on the ports. A drain entry holds the line until the stack
  // owes nothing and the settle timer has run out, which is also how capacity writes are
  // kept away from work in flight. start and cfg_valid get exactly one assignment per edge.
  always @(posedge clk) begin
    stack_beat_t head;
    logic        hold_start;
    logic        hold_cfg;
    if (rst) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      hold_start = start;
      hold_cfg   = cfg_valid;
      if (start && !busy) begin
        owed_replies.push_back(apply_stack_cmd(command, push_value, position));
        hold_start = 1'b0;
        // Idle gap before the next command, with occasional stretches of none at all.
        send_gap = quiet_run ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0) begin
          quiet_run = !quiet_run;
        end
      end
      if (cfg_valid && cfg_ready) begin
        model_cap = cfg_data;
        hold_cfg  = 1'b0;
      end
      if (!hold_start && !hold_cfg && pending_beats.size() != 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else begin
          head = pending_beats[0];
          case (head.kind)
            BEAT_CMD: begin
              command    <= head.op;
              push_value <= head.value;
              position   <= head.pos;
              hold_start = 1'b1;
              void'(pending_beats.pop_front());
            end
            BEAT_CFG: begin
              cfg_data <= head.cap;
              hold_cfg = 1'b1;
              void'(pending_beats.pop_front());
            end
            default: begin
              if (owed_replies.size() != 0) begin
                settle = 0;
              end else if (settle >= SETTLE_CYCLES) begin
                settle = 0;
                void'(pending_beats.pop_front());
              end else begin
                settle++;
              end
            end
          endcase
        end
      end
      start     <= hold_start;
      cfg_valid <= hold_cfg;
    end
  end

  // Monitor. Every done strobe is one result beat and must match the oldest prediction.
  always @(posedge clk) begin
    stack_reply_t want;
    if (!rst && done) begin
      if (owed_replies.size() == 0) begin
        report_mismatch("result beat with no command outstanding");
      end else begin
        want = owed_replies.pop_front();
        if (read_data !== want.data) begin
          report_mismatch($sformatf("read_data %h, expected %h", read_data, want.data));
        end
        if (status !== want.code) begin
          report_mismatch($sformatf("status %0d, expected %0d", status, want.code));
        end
        if (entry_count !== want.count) begin
          report_mismatch($sformatf("entry_count %0d, expected %0d", entry_count,
                                    want.count));
        end
        if (is_empty !== want.empty) begin
          report_mismatch($sformatf("is_empty %b, expected %b", is_empty, want.empty));
        end
        if (is_full !== want.full) begin
          report_mismatch($sformatf("is_full %b, expected %b", is_full, want.full));
        end
      end
    end
  end

  task automatic add_cmd(input logic [2:0] op, input logic signed [WORD_W-1:0] value,
                         input logic [CNT_W-1:0] pos);
    stack_beat_t b;
    b.kind  = BEAT_CMD;
    b.op    = op;
    b.value = value;
    b.pos   = pos;
    b.cap   = '0;
    pending_beats.push_back(b);
  endtask

  // Waits for the stack to go quiet, then rewrites the capacity.
  task automatic add_capacity(input logic [CNT_W-1:0] cap);
    stack_beat_t b;
    b = '0;
    b.kind = BEAT_DRAIN;
    pending_beats.push_back(b);
    b.kind = BEAT_CFG;
    b.cap  = cap;
    pending_beats.push_back(b);
  endtask

  // A run of random commands; push_pct steers the run toward filling or emptying.
  task automatic add_random_run(input int unsigned n, input int unsigned push_pct);
    int unsigned              pick;
    logic [2:0]               op;
    logic signed [WORD_W-1:0] value;
    logic [CNT_W-1:0]         pos;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < push_pct) begin
        op = CMD_PUSH;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40) op = CMD_POP;
        else if (pick < 70) op = CMD_PEEK;
        else if (pick < 82) op = CMD_TOP;
        else if (pick < 94) op = CMD_BOTTOM;
        else op = 3'($urandom_range(5, 7));
      end
      // Mostly arbitrary words, now and then one of the extremes.
      case ($urandom_range(0, 15))
        0: value = 32'sh7FFF_FFFF;
        1: value = 32'sh8000_0000;
        2: value = '0;
        3: value = '1;
        default: value = $urandom;
      endcase
      // Shallow peeks hit more often; the full range keeps the rejects coming.
      pos = ($urandom_range(0, 2) == 0) ? 5'($urandom_range(0, 16)) : 5'($urandom_range(1, 8));
      add_cmd(op, value, pos);
    end
  endtask

  initial begin
    // Directed opening at the reset capacity: every read on an empty stack, the unused
    // codes, extreme words, peeks at both ends and past them, then unwinding.
    add_cmd(CMD_POP, $urandom, 5'd1);
    add_cmd(CMD_TOP, $urandom, 5'd1);
    add_cmd(CMD_BOTTOM, $urandom, 5'd1);
    add_cmd(CMD_PEEK, $urandom, 5'd0);
    add_cmd(CMD_PEEK, $urandom, 5'd16);
    add_cmd(3'd5, $urandom, 5'd3);
    add_cmd(3'd7, $urandom, 5'd31);
    add_cmd(CMD_PUSH, 32'sh7FFF_FFFF, 5'd0);
    add_cmd(CMD_PUSH, 32'sh8000_0000, 5'd0);
    add_cmd(CMD_PUSH, '1, 5'd15);
    add_cmd(CMD_PUSH, '0, 5'd16);
    add_cmd(CMD_PEEK, $urandom, 5'd1);
    add_cmd(CMD_PEEK, $urandom, 5'd4);
    add_cmd(CMD_PEEK, $urandom, 5'd5);
    add_cmd(CMD_PEEK, $urandom, 5'd0);
    add_cmd(CMD_TOP, $urandom, 5'd0);
    add_cmd(CMD_BOTTOM, $urandom, 5'd0);
    add_cmd(3'd6, $urandom, 5'd2);
    add_cmd(CMD_POP, $urandom, 5'd0);
    // Capacity zero with three words held: pushes bounce, reads still work.
    add_capacity(5'd0);
    add_cmd(CMD_PUSH, $urandom, 5'd0);
    add_cmd(CMD_TOP, $urandom, 5'd0);
    add_cmd(CMD_POP, $urandom, 5'd0);
    // A capacity above the depth behaves as the full depth.
    add_capacity(5'd31);
    add_cmd(CMD_PUSH, $urandom, 5'd0);
    add_cmd(CMD_PEEK, $urandom, 5'd2);

    // Random phases, each behind a drain and a capacity write.
    add_capacity(5'd1);
    add_random_run(40, 45);
    add_capacity(5'd0);
    add_random_run(25, 50);
    add_capacity(5'd31);
    add_random_run(60, 70);
    // Lower the capacity under a well-filled stack, then work it back down.
    add_capacity(5'd4);
    add_random_run(30, 25);
    add_capacity(5'd16);
    add_random_run(60, 70);
    add_random_run(40, 20);
    repeat (7) begin
      add_capacity(5'($urandom_range(1, 16)));
      add_random_run(50, $urandom_range(20, 75));
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Sampled away from the active edge so the queues are stable when looked at.
    do begin
      @(negedge clk);
    end while (pending_beats.size() != 0 || start || cfg_valid || owed_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
